@@ rtl/tea_pkg.sv @@
package tea_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned CfgIdxW  = $clog2(KeyWords);

  localparam logic [WordW-1:0] TeaDelta = 32'h9e37_79b9;

  // The two ops carried by each block.
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic             op;
    logic [WordW-1:0] first;
    logic [WordW-1:0] second;
  } blk_t;

  // Round sum for a given round number, modulo 2^32. Called with constants only.
  function automatic logic [WordW-1:0] delta_mul(input int unsigned k);
    logic [2*WordW-1:0] prod;
    prod = 64'(TeaDelta) * 64'(k);
    return prod[WordW-1:0];
  endfunction

  function automatic logic [WordW-1:0] mix_half(input logic [WordW-1:0] x,
                                                input logic [WordW-1:0] sum,
                                                input logic [WordW-1:0] ka,
                                                input logic [WordW-1:0] kb);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    a = (x << 4) + ka;
    b = x + sum;
    c = (x >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

@@ rtl/tea_round.sv @@
module tea_round import tea_pkg::*; #(
  parameter bit               Phase  = 1'b0,
  parameter logic [WordW-1:0] EncSum = '0,
  parameter logic [WordW-1:0] DecSum = '0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  key_t key_i,
  input  logic in_valid_i,
  input  blk_t in_blk_i,
  output logic ready_o,
  input  logic ready_i,
  output logic out_valid_o,
  output blk_t out_blk_o
);

  logic             valid_q;
  blk_t             blk_q;
  blk_t             blk_d;
  logic             upd_first;
  logic [WordW-1:0] src;
  logic [WordW-1:0] dst;
  logic [WordW-1:0] sum;
  logic [WordW-1:0] ka;
  logic [WordW-1:0] kb;
  logic [WordW-1:0] mix;
  logic [WordW-1:0] res;

  // Even stages encrypt into the first half and decrypt into the second;
  // odd stages do the reverse.
  assign upd_first = (Phase == 1'b0) ? (in_blk_i.op == OpEncrypt)
                                     : (in_blk_i.op == OpDecrypt);

  always_comb begin
    src = upd_first ? in_blk_i.second : in_blk_i.first;
    dst = upd_first ? in_blk_i.first  : in_blk_i.second;
    ka  = upd_first ? key_i[0] : key_i[2];
    kb  = upd_first ? key_i[1] : key_i[3];
    sum = (in_blk_i.op == OpDecrypt) ? DecSum : EncSum;
    mix = mix_half(src, sum, ka, kb);
    res = (in_blk_i.op == OpDecrypt) ? (dst - mix) : (dst + mix);
    blk_d = in_blk_i;
    if (upd_first) begin
      blk_d.first = res;
    end else begin
      blk_d.second = res;
    end
  end

  // A stage takes new data when it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_blk_o   = blk_q;

endmodule

@@ rtl/tea_block_cipher.sv @@
// Channel  | Direction | Handshake               | Payload
// input    | in        | in_valid_i / in_stall_o | op_i, block_first_i, block_second_i
// output   | out       | out_valid_o/out_stall_i | out_first_o, out_second_o
// config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each of the 2*ROUND_COUNT pipeline stages computes one Feistel half-round, so a
// block passes through every one of those stage registers in order on its way to the result.
// One block per cycle is accepted while the output is taken without stall.
// A stalled output lets the stages behind it fill any bubbles before the input
// stalls. Reset clears the stage valid bits and the key words.
module tea_block_cipher import tea_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 32  // 1 to 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [WordW-1:0]   block_first_i,
  input  logic [WordW-1:0]   block_second_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WordW-1:0]   out_first_o,
  output logic [WordW-1:0]   out_second_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i
);

  localparam int unsigned Stages = 2 * ROUND_COUNT;

  key_t              key_q;
  blk_t              in_blk;
  logic [Stages-1:0] valid;
  logic [Stages-1:0] ready;
  blk_t              blk [Stages];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign in_blk.op     = op_i;
  assign in_blk.first  = block_first_i;
  assign in_blk.second = block_second_i;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int unsigned Rnd = s / 2;
    localparam logic [WordW-1:0] EncSum = delta_mul(Rnd + 1);
    localparam logic [WordW-1:0] DecSum = delta_mul(ROUND_COUNT - Rnd);

    logic stage_valid_in;
    blk_t stage_blk_in;
    logic stage_ready_in;

    if (s == 0) begin : g_first
      assign stage_valid_in = in_valid_i;
      assign stage_blk_in   = in_blk;
    end else begin : g_next
      assign stage_valid_in = valid[s-1];
      assign stage_blk_in   = blk[s-1];
    end

    if (s == Stages - 1) begin : g_last
      assign stage_ready_in = !out_stall_i;
    end else begin : g_mid
      assign stage_ready_in = ready[s+1];
    end

    tea_round #(
      .Phase  (s % 2 == 1),
      .EncSum (EncSum),
      .DecSum (DecSum)
    ) u_round (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .key_i       (key_q),
      .in_valid_i  (stage_valid_in),
      .in_blk_i    (stage_blk_in),
      .ready_o     (ready[s]),
      .ready_i     (stage_ready_in),
      .out_valid_o (valid[s]),
      .out_blk_o   (blk[s])
    );
  end

  assign in_stall_o   = !ready[0];
  assign out_valid_o  = valid[Stages-1];
  assign out_first_o  = blk[Stages-1].first;
  assign out_second_o = blk[Stages-1].second;

  // The input stalls only with every stage full and the output blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ($countones(valid) == Stages))
    else $error("input stalled while the pipeline has a bubble");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid[0])
    else $error("accepted transaction did not enter the first stage");

endmodule
